/* sv/lvfp_pkg.sv */
// Shared types, character codes and helpers of the label/value frame parser.
package lvfp_pkg;

   localparam int unsigned LABEL_BYTES = 8;
   localparam int unsigned LABEL_W     = LABEL_BYTES * 8;
   localparam int unsigned LLEN_W      = 4;
   localparam int unsigned PEND_W      = 5;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [PEND_W-1:0] MAX_ENTRIES_RESET = 5'd22;
   localparam logic [PEND_W-1:0] PEND_LIMIT        = 5'd31;

   // "Checksum", first character in the low byte
   localparam logic [LABEL_W-1:0] CHECKSUM_WORD = 64'h6D75_736B_6365_6843;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_LABEL = 4'b0010,
      MODE_VALUE = 4'b0100,
      MODE_ASYNC = 4'b1000
   } mode_type;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      ON_EMPTY = 4'b0001,
      ON_O     = 4'b0010,
      ON_ON    = 4'b0100,
      ON_NO    = 4'b1000
   } on_type;

   typedef struct packed {
      logic               entry_kind;
      logic [LABEL_W-1:0] label_word;
      logic [31:0]        value_number;
      logic               value_is_on;
      logic               earlier_dropped;
      logic               sum_ok;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

/* sv/lvfp_core.sv */
// Parser state and per-word update: modes, label packing, number and ON tracking, sum.
module lvfp_core #(
   parameter int unsigned VALUE_BYTES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_vld,
   input  logic [7:0]                  byte_data,
   input  logic [lvfp_pkg::PEND_W-1:0] max_entries,
   output logic                        res_vld,
   output lvfp_pkg::result_type        res
);
   import lvfp_pkg::*;

   localparam int unsigned VLEN_W = $clog2(VALUE_BYTES + 1);
   localparam logic [VLEN_W-1:0] VLEN_MAX = VLEN_W'(VALUE_BYTES);

   mode_type            mode_ff, mode_in;
   logic [LABEL_W-1:0]  label_ff, label_in;
   logic [LLEN_W-1:0]   llen_ff, llen_in;
   logic [VLEN_W-1:0]   vlen_ff, vlen_in;
   logic [31:0]         accum_ff, accum_in;
   phase_type           phase_ff, phase_in;
   logic                neg_ff, neg_in;
   on_type              on_ff, on_in;
   logic [7:0]          sum_ff, sum_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic                ended_ff, ended_in;

   logic                fin;
   logic                is_end;
   logic                dropped;
   logic [PEND_W-1:0]   pend_base;
   logic [7:0]          sum_base;
   logic [31:0]         digit;

   assign is_end  = (label_ff == CHECKSUM_WORD);
   assign dropped = (pend_ff >= max_entries);
   assign digit   = {24'd0, byte_data - CH_ZERO};

   always_comb begin
      mode_in   = mode_ff;
      label_in  = label_ff;
      llen_in   = llen_ff;
      vlen_in   = vlen_ff;
      accum_in  = accum_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      on_in     = on_ff;
      ended_in  = ended_ff;
      pend_in   = pend_ff;
      fin       = 1'b0;
      pend_base = pend_ff;

      unique case (mode_ff) inside
         MODE_LABEL: begin
            if (byte_data == CH_TAB) begin
               mode_in  = MODE_VALUE;
               vlen_in  = '0;
               accum_in = '0;
               phase_in = PH_LEAD;
               neg_in   = 1'b0;
               on_in    = ON_EMPTY;
               ended_in = 1'b0;
            end else if (byte_data == CH_COLON) begin
               mode_in = MODE_ASYNC;
            end else if (llen_ff >= LLEN_W'(LABEL_BYTES)) begin
               // label too long: drop the entry
               mode_in = MODE_IDLE;
            end else begin
               label_in[llen_ff[2:0]*8 +: 8] = byte_data;
               llen_in = llen_ff + 1'b1;
            end
         end
         MODE_VALUE: begin
            if (byte_data == CH_CR) begin
               mode_in = MODE_IDLE;
               fin     = 1'b1;
            end else if (vlen_ff >= VLEN_MAX) begin
               mode_in = MODE_IDLE;
            end else begin
               vlen_in = vlen_ff + 1'b1;
               if (!ended_ff) begin
                  if (byte_data == CH_NUL) begin
                     ended_in = 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_LEAD: begin
                           if (is_space(byte_data)) begin
                              phase_in = PH_LEAD;
                           end else if (byte_data == CH_PLUS || byte_data == CH_MINUS) begin
                              neg_in   = (byte_data == CH_MINUS);
                              phase_in = PH_DIGITS;
                           end else if (is_digit(byte_data)) begin
                              accum_in = digit;
                              phase_in = PH_DIGITS;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        PH_DIGITS: begin
                           if (is_digit(byte_data)) begin
                              accum_in = (accum_ff << 3) + (accum_ff << 1) + digit;
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        default: begin
                           phase_in = phase_ff;
                        end
                     endcase
                     if (on_ff == ON_EMPTY && byte_data == CH_O) begin
                        on_in = ON_O;
                     end else if (on_ff == ON_O && byte_data == CH_N) begin
                        on_in = ON_ON;
                     end else begin
                        on_in = ON_NO;
                     end
                  end
               end
            end
         end
         MODE_IDLE, MODE_ASYNC: begin
            if (byte_data == CH_LF) begin
               mode_in  = MODE_LABEL;
               label_in = '0;
               llen_in  = '0;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // entry count: test on every finished entry, clear on block end
      if (fin) begin
         if (dropped) begin
            pend_base = '0;
         end
         if (is_end) begin
            pend_in = '0;
         end else if (pend_base < PEND_LIMIT) begin
            pend_in = pend_base + 1'b1;
         end else begin
            pend_in = pend_base;
         end
      end

      sum_base = (fin && is_end) ? 8'd0 : sum_ff;
      sum_in   = (mode_in != MODE_ASYNC) ? sum_base + byte_data : sum_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         label_ff <= '0;
         llen_ff  <= '0;
         vlen_ff  <= '0;
         accum_ff <= '0;
         phase_ff <= PH_LEAD;
         neg_ff   <= 1'b0;
         on_ff    <= ON_EMPTY;
         sum_ff   <= '0;
         pend_ff  <= '0;
         ended_ff <= 1'b0;
      end else if (byte_vld) begin
         mode_ff  <= mode_in;
         label_ff <= label_in;
         llen_ff  <= llen_in;
         vlen_ff  <= vlen_in;
         accum_ff <= accum_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         on_ff    <= on_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         ended_ff <= ended_in;
      end
   end

   assign res_vld             = byte_vld && fin;
   assign res.entry_kind      = is_end;
   assign res.label_word      = label_ff;
   assign res.value_number    = neg_ff ? (32'd0 - accum_ff) : accum_ff;
   assign res.value_is_on     = (on_ff == ON_ON);
   assign res.earlier_dropped = dropped;
   assign res.sum_ok          = is_end && (sum_ff == 8'd0);

endmodule

/* sv/label_value_frame_parser.sv */
// Top level of the label/value text frame parser: input word register, parser, result register.
// rsp_tvalid rises once the carriage return word has passed the input word register and the result register.
// Throughput: one input word per cycle; req_tready drops only while both registers are full
//   and rsp_tready is low, and it follows rsp_tready combinationally.
// Reset (synchronous, active high): parser idle, sums and counts cleared, both registers
//   empty, max_entries_per_block back to 22.
module label_value_frame_parser #(
   parameter int unsigned VALUE_BYTES = 32
) (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [63:0] label_word, [95:64] value_number,
                                     // [96] value_is_on, [97] earlier_dropped,
                                     // [98] sum_ok, [103:99] zero
   output logic         rsp_tuser,   // [0] entry_kind
   // configuration
   input  logic         csr_wen,
   input  logic [4:0]   csr_wdata    // max_entries_per_block
);
   import lvfp_pkg::*;

   logic              in_vld_ff;
   logic [7:0]        in_data_ff;
   logic              proc;
   logic [PEND_W-1:0] max_ff;
   logic              core_vld;
   result_type        core_res;
   logic              out_vld_ff;
   result_type        out_ff;

   // process the held word whenever the result register can take a result
   assign proc       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc;

   // hold the configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RESET;
      end else if (csr_wen) begin
         max_ff <= csr_wdata;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   lvfp_core #(
      .VALUE_BYTES(VALUE_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_vld   (proc),
      .byte_data  (in_data_ff),
      .max_entries(max_ff),
      .res_vld    (core_vld),
      .res        (core_res)
   );

   // result register: load on every processed word, drain when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (proc) begin
         out_vld_ff <= core_vld;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && core_vld) begin
         out_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.entry_kind;
   assign rsp_tdata  = {5'd0, out_ff.sum_ok, out_ff.earlier_dropped, out_ff.value_is_on,
                        out_ff.value_number, out_ff.label_word};

endmodule
